@@ hdl/pvmd_pkg.sv @@
// shared types and constants for the pid velocity motor drive
package pvmd_pkg;

  localparam int OPB_W = 24;    // width of the unsigned serial operand
  localparam int DER_W = 37;    // derivative term, signed
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INT_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INT_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_LIMIT = 3'd4;

  localparam logic [23:0] PROP_GAIN_RST  = 24'd1310720;
  localparam logic [23:0] INT_GAIN_RST   = 24'd655;
  localparam logic [23:0] DERIV_GAIN_RST = 24'd0;
  localparam logic [22:0] INT_LIMIT_RST  = 23'd65280;
  localparam logic [7:0]  DUTY_LIMIT_RST = 8'd100;

  // 5/380 counts scale with ms->s and Q16.8: 64000 / 19
  localparam logic [OPB_W-1:0] VEL_SCALE = 24'd64000;
  localparam logic [OPB_W-1:0] MS_PER_S  = 24'd1000;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
    logic    clr;
  } alu_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VEL_MUL,
    ST_VEL_DIV,
    ST_INT_MUL,
    ST_INT_DIV,
    ST_DER_MUL,
    ST_DER_DIV,
    ST_P_MUL,
    ST_I_MUL,
    ST_D_MUL,
    ST_OUT
  } pvmd_state_e;

endpackage

@@ hdl/pvmd_serial_alu.sv @@
// bit-serial shift-add multiply-accumulate and restoring divide unit
module pvmd_serial_alu #(
  parameter int AW = 64,
  parameter int BW = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pvmd_pkg::alu_cmd_t   cmd_i,
  input  logic signed [AW-1:0] a_i,
  input  logic [BW-1:0]        b_i,
  output logic signed [AW-1:0] res_o,
  output pvmd_pkg::alu_sts_t   sts_o
);

  localparam int CW = $clog2(AW);

  logic               busy_q, done_q;
  pvmd_pkg::alu_op_e  op_q;
  logic [CW-1:0]      cnt_q;
  logic signed [AW-1:0] acc_q, a_q;
  logic [AW-1:0]      mag_q;
  logic [BW-1:0]      b_q, rem_q;
  logic               neg_q;

  logic [BW:0]        rem_sh, rem_sub;
  logic               ge;
  logic [AW-1:0]      quo;
  logic               mul_last, div_last;

  always_comb begin
    rem_sh   = {rem_q, mag_q[AW-1]};
    rem_sub  = rem_sh - {1'b0, b_q};
    ge       = (rem_sh >= {1'b0, b_q});
    quo      = {mag_q[AW-2:0], ge};
    mul_last = busy_q && (op_q == pvmd_pkg::ALU_MUL) && (b_q[BW-1:1] == '0);
    div_last = busy_q && (op_q == pvmd_pkg::ALU_DIV) && (cnt_q == CW'(AW - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= pvmd_pkg::ALU_MUL;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        op_q   <= cmd_i.op;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (mul_last || div_last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      b_q   <= b_i;
      a_q   <= a_i;
      rem_q <= '0;
      neg_q <= a_i[AW-1];
      mag_q <= a_i[AW-1] ? AW'(-a_i) : AW'(a_i);
      if (cmd_i.op == pvmd_pkg::ALU_MUL && cmd_i.clr) begin
        acc_q <= '0;
      end
    end else if (busy_q) begin
      if (op_q == pvmd_pkg::ALU_MUL) begin
        if (b_q[0]) begin
          acc_q <= acc_q + a_q;
        end
        a_q <= a_q <<< 1;
        b_q <= b_q >> 1;
      end else begin
        // one quotient bit per cycle, magnitudes only
        rem_q <= ge ? rem_sub[BW-1:0] : rem_sh[BW-1:0];
        mag_q <= quo;
        if (div_last) begin
          acc_q <= neg_q ? -$signed(quo) : $signed(quo);
        end
      end
    end
  end

  assign res_o      = acc_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

@@ hdl/pid_velocity_motor_drive_core.sv @@
// pid velocity controller top level: sequencer, state and stream ports
// one tick runs nine serial steps on a shared multiply/divide unit; every step
// is launched and then handed off, a divide works through every bit of the
// dividend and a multiply through its unsigned operand up to the top set bit
// the next tick can be accepted in the cycle after the result loads
// reset clears the stored count, error and integral and loads default gains and limits
module pid_velocity_motor_drive_core #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // encoder_count[31:0], elapsed_ms[47:32], target_velocity[71:48], limit_switch[72]
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // drive_forward[0], drive_reverse[1], duty[9:2], limit_stop[10],
  // measured_velocity[34:11]
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [pvmd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pvmd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AW = (COUNT_WIDTH + 17 > 64) ? COUNT_WIDTH + 17 : 64;
  localparam int BW = pvmd_pkg::OPB_W;
  localparam int DW = pvmd_pkg::DER_W;
  localparam int XW = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

  // configuration
  logic [23:0] prop_gain_q, int_gain_q, deriv_gain_q;
  logic [22:0] int_limit_q;
  logic [7:0]  duty_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q  <= pvmd_pkg::PROP_GAIN_RST;
      int_gain_q   <= pvmd_pkg::INT_GAIN_RST;
      deriv_gain_q <= pvmd_pkg::DERIV_GAIN_RST;
      int_limit_q  <= pvmd_pkg::INT_LIMIT_RST;
      duty_limit_q <= pvmd_pkg::DUTY_LIMIT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pvmd_pkg::CFG_PROP_GAIN:  prop_gain_q  <= cfg_data_i;
        pvmd_pkg::CFG_INT_GAIN:   int_gain_q   <= cfg_data_i;
        pvmd_pkg::CFG_DERIV_GAIN: deriv_gain_q <= cfg_data_i;
        pvmd_pkg::CFG_INT_LIMIT:  int_limit_q  <= cfg_data_i[22:0];
        pvmd_pkg::CFG_DUTY_LIMIT: duty_limit_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // input fields
  logic signed [31:0] in_count;
  logic [15:0]        in_dt;
  logic signed [23:0] in_target;
  logic               in_switch;
  logic               in_acc;

  assign in_count  = s_axis_tdata[31:0];
  assign in_dt     = s_axis_tdata[47:32];
  assign in_target = s_axis_tdata[71:48];
  assign in_switch = s_axis_tdata[72];
  assign in_acc    = s_axis_tvalid && s_axis_tready;

  pvmd_pkg::pvmd_state_e state_q, state_d;
  logic launched_q;

  logic [31:0]                 prev_count_q;
  logic signed [COUNT_WIDTH-1:0] delta_q;
  logic [15:0]                 dt_q;
  logic [BW-1:0]               div19_q;
  logic signed [23:0]          target_q, vel_q, integ_q;
  logic                        switch_q;
  logic signed [24:0]          err_q, prev_err_q;
  logic signed [DW-1:0]        deriv_q;

  logic [15:0]         dt_fix;
  logic signed [XW-1:0] diff_x;
  logic signed [25:0]  err_diff;

  always_comb begin
    dt_fix   = (in_dt == '0) ? 16'd1 : in_dt;
    diff_x   = XW'(in_count) - XW'($signed(prev_count_q));
    err_diff = {err_q[24], err_q} - {prev_err_q[24], prev_err_q};
  end

  // serial unit
  pvmd_pkg::alu_cmd_t   alu_cmd;
  pvmd_pkg::alu_sts_t   alu_sts;
  logic signed [AW-1:0] alu_a, alu_res;
  logic [BW-1:0]        alu_b;

  pvmd_serial_alu #(
    .AW(AW),
    .BW(BW)
  ) u_alu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (alu_cmd),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res),
    .sts_o (alu_sts)
  );

  // result shaping
  logic signed [AW-1:0] vmax, vmin, vel_sat, ilim, isum, iclamp;
  logic signed [AW-1:0] acc_bias, drv_q, dlim, drv_c;
  logic signed [24:0]   err_new;
  logic                 stop, out_load;
  logic signed [8:0]    drive;

  always_comb begin
    // velocity saturates symmetrically
    vmax    = AW'(24'sh7FFFFF);
    vmin    = -vmax;
    vel_sat = (alu_res > vmax) ? vmax : ((alu_res < vmin) ? vmin : alu_res);
    err_new = {target_q[23], target_q} - {vel_sat[23], vel_sat[23:0]};

    ilim    = $signed({{(AW-23){1'b0}}, int_limit_q});
    isum    = $signed({{(AW-24){integ_q[23]}}, integ_q}) + alu_res;
    iclamp  = (isum > ilim) ? ilim : ((isum < -ilim) ? -ilim : isum);

    // truncate toward zero on the 2^24 scale
    acc_bias = alu_res + (alu_res[AW-1] ? $signed(AW'(24'hFFFFFF)) : $signed(AW'(0)));
    drv_q    = acc_bias >>> 24;
    dlim     = $signed({{(AW-8){1'b0}}, duty_limit_q});
    drv_c    = (drv_q > dlim) ? dlim : ((drv_q < -dlim) ? -dlim : drv_q);
    drive    = drv_c[8:0];

    stop     = switch_q && target_q[23];
  end

  // sequencer
  always_comb begin
    state_d       = state_q;
    alu_cmd.start = 1'b0;
    alu_cmd.op    = pvmd_pkg::ALU_MUL;
    alu_cmd.clr   = 1'b1;
    alu_a         = alu_res;
    alu_b         = pvmd_pkg::MS_PER_S;
    out_load      = 1'b0;
    s_axis_tready = 1'b0;

    case (state_q)
      pvmd_pkg::ST_VEL_MUL: begin
        alu_a = AW'(delta_q);
        alu_b = pvmd_pkg::VEL_SCALE;
      end
      pvmd_pkg::ST_VEL_DIV: begin
        alu_cmd.op = pvmd_pkg::ALU_DIV;
        alu_b      = div19_q;
      end
      pvmd_pkg::ST_INT_MUL: begin
        alu_a = AW'(err_q);
        alu_b = BW'(dt_q);
      end
      pvmd_pkg::ST_INT_DIV: begin
        alu_cmd.op = pvmd_pkg::ALU_DIV;
      end
      pvmd_pkg::ST_DER_MUL: begin
        alu_a = AW'(err_diff);
      end
      pvmd_pkg::ST_DER_DIV: begin
        alu_cmd.op = pvmd_pkg::ALU_DIV;
        alu_b      = BW'(dt_q);
      end
      pvmd_pkg::ST_P_MUL: begin
        alu_a = AW'(err_q);
        alu_b = prop_gain_q;
      end
      pvmd_pkg::ST_I_MUL: begin
        alu_a       = AW'(integ_q);
        alu_b       = int_gain_q;
        alu_cmd.clr = 1'b0;
      end
      pvmd_pkg::ST_D_MUL: begin
        alu_a       = AW'(deriv_q);
        alu_b       = deriv_gain_q;
        alu_cmd.clr = 1'b0;
      end
      default: ;
    endcase

    case (state_q)
      pvmd_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) state_d = pvmd_pkg::ST_VEL_MUL;
      end
      pvmd_pkg::ST_OUT: begin
        out_load = !m_axis_tvalid || m_axis_tready;
        if (out_load) state_d = pvmd_pkg::ST_IDLE;
      end
      default: begin
        alu_cmd.start = !launched_q;
        if (alu_sts.done) begin
          case (state_q)
            pvmd_pkg::ST_VEL_MUL: state_d = pvmd_pkg::ST_VEL_DIV;
            pvmd_pkg::ST_VEL_DIV: state_d = pvmd_pkg::ST_INT_MUL;
            pvmd_pkg::ST_INT_MUL: state_d = pvmd_pkg::ST_INT_DIV;
            pvmd_pkg::ST_INT_DIV: state_d = pvmd_pkg::ST_DER_MUL;
            pvmd_pkg::ST_DER_MUL: state_d = pvmd_pkg::ST_DER_DIV;
            pvmd_pkg::ST_DER_DIV: state_d = pvmd_pkg::ST_P_MUL;
            pvmd_pkg::ST_P_MUL:   state_d = pvmd_pkg::ST_I_MUL;
            pvmd_pkg::ST_I_MUL:   state_d = pvmd_pkg::ST_D_MUL;
            default:              state_d = pvmd_pkg::ST_OUT;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= pvmd_pkg::ST_IDLE;
      launched_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (alu_cmd.start) launched_q <= 1'b1;
      else if (alu_sts.done) launched_q <= 1'b0;
    end
  end

  // controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_count_q <= '0;
      prev_err_q   <= '0;
      integ_q      <= '0;
    end else begin
      if (in_acc) prev_count_q <= in_count;
      if (state_q == pvmd_pkg::ST_INT_DIV && alu_sts.done) integ_q <= iclamp[23:0];
      if (state_q == pvmd_pkg::ST_DER_DIV && alu_sts.done) prev_err_q <= err_q;
      if (out_load && stop) begin
        integ_q      <= '0;
        prev_count_q <= '0;
      end
    end
  end

  // per-tick working registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      delta_q  <= diff_x[COUNT_WIDTH-1:0];
      dt_q     <= dt_fix;
      div19_q  <= BW'({dt_fix, 4'b0}) + BW'({dt_fix, 1'b0}) + BW'(dt_fix);
      target_q <= in_target;
      switch_q <= in_switch;
    end
    if (state_q == pvmd_pkg::ST_VEL_DIV && alu_sts.done) begin
      vel_q <= vel_sat[23:0];
      err_q <= err_new;
    end
    if (state_q == pvmd_pkg::ST_DER_DIV && alu_sts.done) deriv_q <= alu_res[DW-1:0];
  end

  // output register
  logic       out_valid_q, fwd_q, rev_q, stop_q;
  logic [7:0] duty_q;
  logic signed [23:0] vel_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      fwd_q     <= !stop && (target_q != '0) && !drive[8];
      rev_q     <= !stop && (target_q != '0) && drive[8];
      duty_q    <= (stop || target_q == '0) ? 8'd0 :
                   (drive[8] ? 8'(-drive) : drive[7:0]);
      stop_q    <= stop;
      vel_out_q <= vel_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, vel_out_q, stop_q, duty_q, rev_q, fwd_q};

  a_alu_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_cmd.start |-> !alu_sts.busy)
    else $error("serial unit started while busy");

  a_pins_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(fwd_q && rev_q))
    else $error("both direction pins high");

  a_duty_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> duty_q <= duty_limit_q)
    else $error("duty above limit");

  a_stop_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && stop_q) |-> (!fwd_q && !rev_q && duty_q == 8'd0))
    else $error("limit stop with drive active");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == pvmd_pkg::ST_OUT)
    else $error("result raised outside output step");

endmodule

@@ tb/pvmd_checker.sv @@
// checker for the pid velocity motor drive: predicts each tick and compares results
module pvmd_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [pvmd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pvmd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [23:0] velocity;
    logic        stop;
    logic [7:0]  duty;
    logic        reverse;
    logic        forward;
  } drive_result_t;

  longint prop_gain, int_gain, deriv_gain, int_limit, duty_limit;
  logic [31:0] prev_count_seen;
  longint last_error, int_sum;
  drive_result_t expected_q[$];

  assign pending_o = expected_q.size();

  function automatic longint sat(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic drive_result_t predict_drive(logic [79:0] d);
    drive_result_t r;
    longint dt, target, delta, vel, err, deriv, acc, drive;
    logic [31:0] diff;
    logic pressed;
    dt = longint'(d[47:32]);
    target = longint'($signed(d[71:48]));
    pressed = d[72];
    if (dt == 0) dt = 1;
    diff = d[31:0] - prev_count_seen;
    delta = longint'($signed(diff));
    prev_count_seen = d[31:0];
    vel = sat(delta * 64000 / (19 * dt), 8388607);
    err = target - vel;
    int_sum = sat(int_sum + err * dt / 1000, int_limit);
    deriv = (err - last_error) * 1000 / dt;
    last_error = err;
    acc = prop_gain * err + int_gain * int_sum + deriv_gain * deriv;
    drive = sat(acc / 16777216, duty_limit);
    r = '0;
    r.stop = pressed && target < 0;
    if (r.stop) begin
      target = 0;
      drive = 0;
      int_sum = 0;
      prev_count_seen = '0;
    end
    if (target != 0) begin
      if (drive >= 0) begin
        r.forward = 1'b1;
        r.duty = drive[7:0];
      end else begin
        r.reverse = 1'b1;
        r.duty = 8'(-drive);
      end
    end
    r.velocity = vel[23:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    drive_result_t got, want;
    if (!rst_ni) begin
      prop_gain  = pvmd_pkg::PROP_GAIN_RST;
      int_gain   = pvmd_pkg::INT_GAIN_RST;
      deriv_gain = pvmd_pkg::DERIV_GAIN_RST;
      int_limit  = pvmd_pkg::INT_LIMIT_RST;
      duty_limit = pvmd_pkg::DUTY_LIMIT_RST;
      prev_count_seen = '0;
      last_error = 0;
      int_sum = 0;
      expected_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          pvmd_pkg::CFG_PROP_GAIN:  prop_gain  = cfg_data_i;
          pvmd_pkg::CFG_INT_GAIN:   int_gain   = cfg_data_i;
          pvmd_pkg::CFG_DERIV_GAIN: deriv_gain = cfg_data_i;
          pvmd_pkg::CFG_INT_LIMIT:  int_limit  = cfg_data_i[22:0];
          pvmd_pkg::CFG_DUTY_LIMIT: duty_limit = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[34:0];
        if (expected_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected result %h", got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want || m_axis_tdata[39:35] !== '0) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("mismatch: fwd %b/%b rev %b/%b duty %0d/%0d stop %b/%b vel %h/%h",
                       want.forward, got.forward, want.reverse, got.reverse,
                       want.duty, got.duty, want.stop, got.stop,
                       want.velocity, got.velocity);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(predict_drive(s_axis_tdata));
    end
  end
endmodule

@@ tb/tb_pid_velocity_motor_drive_core.sv @@
// testbench top for the pid velocity motor drive: stimulus, phases and verdict
module tb_pid_velocity_motor_drive_core;

  // index with no register behind it
  localparam logic [pvmd_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [pvmd_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [pvmd_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  int fail_count, pending;
  int send_idle_pct = 0, recv_stall_pct = 0;
  logic [31:0] enc_pos = '0;

  pid_velocity_motor_drive_core u_top (.*);

  pvmd_checker u_check (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("** pid_velocity_motor_drive_core: FAILED **");
    $finish;
  end

  // receiver stalls at random
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // valid stays up after the write; the next tick transaction drops it
  task automatic write_reg(logic [pvmd_pkg::CFG_IDX_W-1:0] idx,
                           logic [pvmd_pkg::CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // valid stays up after acceptance; idle cycles or drain drop it
  task automatic send_tick(logic [31:0] cnt, logic [15:0] ms, logic [23:0] tgt, logic sw);
    cfg_valid_i <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, sw, tgt, ms, cnt};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (400) @(posedge clk_i);
  endtask

  // mostly realistic ticks: small motion, small dt, occasional extremes
  task automatic random_tick();
    logic [15:0] ms;
    logic [23:0] tgt;
    int r;
    r = $urandom_range(99);
    if (r < 80) begin
      enc_pos = enc_pos + 32'($signed($urandom_range(4000)) - 2000);
      ms = 16'($urandom_range(20));
      tgt = 24'($signed($urandom_range(20000)) - 10000);
    end else begin
      enc_pos = $urandom;
      ms = 16'($urandom);
      tgt = 24'($urandom);
    end
    if ($urandom_range(9) == 0) tgt = '0;
    send_tick(enc_pos, ms, tgt, $urandom_range(5) == 0);
    if (s_axis_tdata[72] && s_axis_tdata[71]) enc_pos = '0;
  endtask

  task automatic random_config(bit extreme);
    if (extreme) begin
      write_reg(pvmd_pkg::CFG_PROP_GAIN, 24'hFFFFFF);
      write_reg(pvmd_pkg::CFG_INT_GAIN, 24'hFFFFFF);
      write_reg(pvmd_pkg::CFG_DERIV_GAIN, 24'hFFFFFF);
      write_reg(pvmd_pkg::CFG_INT_LIMIT, 24'h7FFFFF);
      write_reg(pvmd_pkg::CFG_DUTY_LIMIT, 24'hFF);
    end else begin
      write_reg(pvmd_pkg::CFG_PROP_GAIN, 24'($urandom_range(2_000_000)));
      write_reg(pvmd_pkg::CFG_INT_GAIN, 24'($urandom_range(70_000)));
      write_reg(pvmd_pkg::CFG_DERIV_GAIN, 24'($urandom_range(5_000)));
      write_reg(pvmd_pkg::CFG_INT_LIMIT, 24'($urandom));
      write_reg(pvmd_pkg::CFG_DUTY_LIMIT, 24'($urandom));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, zero dt, wrap, saturation, zero target, limit stop
    send_tick(32'd0, 16'd0, 24'd0, 1'b0);
    send_tick(32'd100, 16'd0, 24'd2560, 1'b0);
    send_tick(32'h7FFFFFFF, 16'd1, 24'h7FFFFF, 1'b0);
    send_tick(32'h80000000, 16'd1, 24'h800000, 1'b0);
    send_tick(32'h80000000, 16'hFFFF, 24'h800000, 1'b1);
    send_tick(32'd500, 16'd10, 24'hFFFF00, 1'b1);
    send_tick(32'd500, 16'd10, 24'd256, 1'b1);
    send_tick(32'hFFFFFFFF, 16'hFFFF, 24'hFFFFFF, 1'b0);
    send_tick(32'd5, 16'd10, 24'd1, 1'b0);
    send_tick(32'd5, 16'd10, 24'd0, 1'b1);
    drain();
    write_reg(pvmd_pkg::CFG_DUTY_LIMIT, 24'h0);
    write_reg(pvmd_pkg::CFG_INT_LIMIT, 24'h0);
    write_reg(pvmd_pkg::CFG_PROP_GAIN, 24'h0);
    write_reg(pvmd_pkg::CFG_INT_GAIN, 24'h0);
    write_reg(pvmd_pkg::CFG_DERIV_GAIN, 24'h0);
    write_reg(CFG_NO_REG, 24'hFFFFFF);
    send_tick(32'd1000, 16'd5, 24'd3000, 1'b0);
    send_tick(32'd0, 16'd5, 24'hFFF000, 1'b0);
    drain();
    random_config(1'b1);
    send_tick(32'd40000, 16'd1, 24'd5000, 1'b0);
    send_tick(32'd0, 16'd1, 24'hFFEC00, 1'b0);
    send_tick(32'd3, 16'd7, 24'd100, 1'b0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      if (ph == 0) begin
        write_reg(pvmd_pkg::CFG_PROP_GAIN, pvmd_pkg::PROP_GAIN_RST);
        write_reg(pvmd_pkg::CFG_INT_GAIN, pvmd_pkg::INT_GAIN_RST);
        write_reg(pvmd_pkg::CFG_DERIV_GAIN, pvmd_pkg::DERIV_GAIN_RST);
        write_reg(pvmd_pkg::CFG_INT_LIMIT, 24'(pvmd_pkg::INT_LIMIT_RST));
        write_reg(pvmd_pkg::CFG_DUTY_LIMIT, 24'(pvmd_pkg::DUTY_LIMIT_RST));
      end else begin
        random_config(ph == 5);
      end
      for (int i = 0; i < 150; i++) begin
        random_tick();
        // wait for an empty pipe now and then
        if (i == 75) begin
          s_axis_tvalid <= 1'b0;
          do @(posedge clk_i); while (pending != 0);
        end
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("** pid_velocity_motor_drive_core: PASSED **");
    end else begin
      $display("** pid_velocity_motor_drive_core: FAILED **");
    end
    $finish;
  end
endmodule
